[src/rbcm_pkg.sv]
package rbcm_pkg;

  localparam int unsigned InW      = 152;
  localparam int unsigned OutW     = 8;
  localparam int unsigned CfgW     = 14;
  localparam int unsigned HtW      = 12;
  localparam int unsigned LtW      = 14;
  localparam int unsigned TrigW    = 16;

  typedef enum logic {
    REG_HEIGHT_THRESHOLD = 1'b0,
    REG_LENGTH_THRESHOLD = 1'b1
  } reg_index_t;

  typedef logic signed [TrigW-1:0] trig_t;

  function automatic logic [14:0] sine_table(input logic [5:0] k);
    logic [14:0] t;
    case (k)
      6'd0:  t = 15'd0;
      6'd1:  t = 15'd804;
      6'd2:  t = 15'd1606;
      6'd3:  t = 15'd2404;
      6'd4:  t = 15'd3196;
      6'd5:  t = 15'd3981;
      6'd6:  t = 15'd4756;
      6'd7:  t = 15'd5520;
      6'd8:  t = 15'd6270;
      6'd9:  t = 15'd7005;
      6'd10: t = 15'd7723;
      6'd11: t = 15'd8423;
      6'd12: t = 15'd9102;
      6'd13: t = 15'd9760;
      6'd14: t = 15'd10394;
      6'd15: t = 15'd11003;
      6'd16: t = 15'd11585;
      6'd17: t = 15'd12140;
      6'd18: t = 15'd12665;
      6'd19: t = 15'd13160;
      6'd20: t = 15'd13623;
      6'd21: t = 15'd14053;
      6'd22: t = 15'd14449;
      6'd23: t = 15'd14811;
      6'd24: t = 15'd15137;
      6'd25: t = 15'd15426;
      6'd26: t = 15'd15679;
      6'd27: t = 15'd15893;
      6'd28: t = 15'd16069;
      6'd29: t = 15'd16207;
      6'd30: t = 15'd16305;
      6'd31: t = 15'd16364;
      6'd32: t = 15'd16384;
      default: t = 15'd0;
    endcase
    return t;
  endfunction

endpackage

[src/rbcm_sincos.sv]
module rbcm_sincos (
  input  logic [15:0]   yaw,
  output rbcm_pkg::trig_t sin_q14,
  output rbcm_pkg::trig_t cos_q14
);
  import rbcm_pkg::*;

  function automatic logic [14:0] quarter_sine(input logic [14:0] u);
    logic [5:0]  i;
    logic [8:0]  f;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [19:0] prod;
    logic [14:0] r;
    i = {1'b0, u[13:9]};
    f = u[8:0];
    lo = sine_table(i);
    hi = sine_table(i + 6'd1);
    prod = 20'(hi - lo) * 20'(f) + 20'd256;
    r = lo + 15'(prod >> 9);
    if (u[14]) begin
      r = 15'd16384;
    end
    return r;
  endfunction

  function automatic trig_t sine_q14(input logic [15:0] a);
    logic [14:0] m;
    logic [14:0] rr;
    rr = {1'b0, a[13:0]};
    if (a[14]) begin
      m = quarter_sine(15'd16384 - rr);
    end else begin
      m = quarter_sine(rr);
    end
    if (a[15]) begin
      return -$signed({1'b0, m});
    end
    return $signed({1'b0, m});
  endfunction

  assign sin_q14 = sine_q14(yaw);
  assign cos_q14 = sine_q14(yaw + 16'd16384);

endmodule

[src/rotated_box_cluster_match_top.sv]
// Channel  Direction  Payload
// s_axis   in         one box and cluster pair per word (fields listed at s_tdata)
// m_axis   out        match flags per word (fields listed at m_tdata)
// cfg      in         threshold writes, one per cycle when cfg_wen is high
//
// Seven register stages: sine lookup, corner products, rounding, offsets,
// area products, cross differences, area sums. One word enters every cycle
// unless a stall on m_tready holds the pipeline.
// rst clears the valid bits and restores both thresholds to 256.
// A stall on m_tready holds every stage, so s_tready falls with it.
module rotated_box_cluster_match_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // box_x, box_y, box_length, box_width, box_height, box_yaw,
  // cluster_x, cluster_y, cluster_diagonal, cluster_height, zero pad
  input  logic [rbcm_pkg::InW-1:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // matched, centre_inside, zero pad
  output logic [rbcm_pkg::OutW-1:0] m_tdata,
  input  logic        cfg_wen,
  input  logic        cfg_addr,
  input  logic [rbcm_pkg::CfgW-1:0] cfg_wdata
);
  import rbcm_pkg::*;

  logic [HtW-1:0] height_limit;
  logic [LtW-1:0] length_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_limit     <= HtW'(256);
      length_threshold <= LtW'(256);
    end else if (cfg_wen) begin
      case (reg_index_t'(cfg_addr))
        REG_HEIGHT_THRESHOLD: height_limit <= cfg_wdata[HtW-1:0];
        REG_LENGTH_THRESHOLD: length_threshold <= cfg_wdata[LtW-1:0];
        default: ;
      endcase
    end
  end

  logic [7:1] vld;
  logic       en;
  assign en = !vld[7] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], s_tvalid};
    end
  end

  // Field unpacking.
  logic signed [16:0] box_x, box_y, cluster_x, cluster_y;
  logic [13:0] box_length, box_width;
  logic [11:0] box_height, cluster_height;
  logic [15:0] box_yaw;
  logic [14:0] cluster_diagonal;
  assign box_x            = $signed(s_tdata[16:0]);
  assign box_y            = $signed(s_tdata[33:17]);
  assign box_length       = s_tdata[47:34];
  assign box_width        = s_tdata[61:48];
  assign box_height       = s_tdata[73:62];
  assign box_yaw          = s_tdata[89:74];
  assign cluster_x        = $signed(s_tdata[106:90]);
  assign cluster_y        = $signed(s_tdata[123:107]);
  assign cluster_diagonal = s_tdata[138:124];
  assign cluster_height   = s_tdata[150:139];

  trig_t sin_v, cos_v;
  rbcm_sincos u_sincos (
    .yaw     (box_yaw),
    .sin_q14 (sin_v),
    .cos_q14 (cos_v)
  );

  // Stage 1.
  logic signed [12:0] hdiff;
  logic [12:0]        hdiff_abs;
  logic signed [15:0] wexcess;
  logic signed [15:0] dval;
  assign hdiff     = $signed({1'b0, box_height}) - $signed({1'b0, cluster_height});
  assign hdiff_abs = hdiff[12] ? 13'(-hdiff) : 13'(hdiff);
  assign wexcess   = $signed({2'b0, box_width}) - $signed({1'b0, cluster_diagonal});
  assign dval      = $signed({1'b0, cluster_diagonal}) - $signed({2'b0, length_threshold});

  trig_t              s1_s, s1_c;
  logic [13:0]        s1_len, s1_wid;
  logic signed [17:0] s1_px, s1_py;
  logic               s1_ok, s1_dpos;
  logic [14:0]        s1_d;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_s    <= sin_v;
      s1_c    <= cos_v;
      s1_len  <= box_length;
      s1_wid  <= box_width;
      s1_px   <= 18'(cluster_x) - 18'(box_x);
      s1_py   <= 18'(cluster_y) - 18'(box_y);
      s1_ok   <= (hdiff_abs <= 13'(height_limit))
              && !(wexcess > $signed({2'b0, length_threshold}));
      s1_dpos <= dval > 16'sd0;
      s1_d    <= dval[14:0];
    end
  end

  // Stage 2: corner products and diagonal squares.
  logic signed [30:0] s2_lc, s2_ls, s2_wc, s2_ws;
  logic [29:0]        s2_dd;
  logic [28:0]        s2_ll;
  logic signed [17:0] s2_px, s2_py;
  logic               s2_ok, s2_dpos;
  logic signed [14:0] len_s, wid_s;
  assign len_s = $signed({1'b0, s1_len});
  assign wid_s = $signed({1'b0, s1_wid});

  always_ff @(posedge clk) begin
    if (en) begin
      s2_lc   <= 31'(len_s * s1_c);
      s2_ls   <= 31'(len_s * s1_s);
      s2_wc   <= 31'(wid_s * s1_c);
      s2_ws   <= 31'(wid_s * s1_s);
      s2_dd   <= 30'(s1_d) * 30'(s1_d);
      s2_ll   <= 29'(s1_len) * 29'(s1_len) + 29'(s1_wid) * 29'(s1_wid);
      s2_px   <= s1_px;
      s2_py   <= s1_py;
      s2_ok   <= s1_ok;
      s2_dpos <= s1_dpos;
    end
  end

  // Stage 3: corners rounded to Q.8, halves up.
  function automatic logic signed [16:0] round_q8(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = (v + 32'sd16384) >>> 15;
    return t[16:0];
  endfunction

  logic signed [31:0] lc_e, ls_e, wc_e, ws_e;
  assign lc_e = 32'(s2_lc);
  assign ls_e = 32'(s2_ls);
  assign wc_e = 32'(s2_wc);
  assign ws_e = 32'(s2_ws);

  logic signed [16:0] s3_rx [4];
  logic signed [16:0] s3_ry [4];
  logic signed [17:0] s3_px, s3_py;
  logic               s3_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rx[0] <= round_q8(lc_e - ws_e);
      s3_ry[0] <= round_q8(ls_e + wc_e);
      s3_rx[1] <= round_q8(lc_e + ws_e);
      s3_ry[1] <= round_q8(ls_e - wc_e);
      s3_rx[2] <= round_q8(-lc_e + ws_e);
      s3_ry[2] <= round_q8(-ls_e - wc_e);
      s3_rx[3] <= round_q8(-lc_e - ws_e);
      s3_ry[3] <= round_q8(-ls_e + wc_e);
      s3_px    <= s2_px;
      s3_py    <= s2_py;
      s3_ok    <= s2_ok && !(s2_dpos && (s2_dd > 30'(s2_ll)));
    end
  end

  // Stage 4: corners relative to the cluster centre and to corner zero.
  logic signed [18:0] s4_ax [4];
  logic signed [18:0] s4_ay [4];
  logic signed [17:0] s4_ex [3];
  logic signed [17:0] s4_ey [3];
  logic               s4_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s4_ax[k] <= 19'(s3_rx[k]) - 19'(s3_px);
        s4_ay[k] <= 19'(s3_ry[k]) - 19'(s3_py);
      end
      for (int k = 0; k < 3; k++) begin
        s4_ex[k] <= 18'(s3_rx[k+1]) - 18'(s3_rx[0]);
        s4_ey[k] <= 18'(s3_ry[k+1]) - 18'(s3_ry[0]);
      end
      s4_ok <= s3_ok;
    end
  end

  // Stage 5: cross-product terms.
  logic signed [37:0] s5_pa [4];
  logic signed [37:0] s5_pb [4];
  logic signed [35:0] s5_ra [2];
  logic signed [35:0] s5_rb [2];
  logic               s5_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s5_pa[k] <= s4_ax[k] * s4_ay[(k+1)%4];
        s5_pb[k] <= s4_ay[k] * s4_ax[(k+1)%4];
      end
      for (int k = 0; k < 2; k++) begin
        s5_ra[k] <= s4_ex[k] * s4_ey[k+1];
        s5_rb[k] <= s4_ey[k] * s4_ex[k+1];
      end
      s5_ok <= s4_ok;
    end
  end

  // Stage 6: doubled triangle areas.
  logic signed [38:0] tdiff [4];
  logic signed [36:0] rdiff [2];
  logic [38:0]        s6_t [4];
  logic [36:0]        s6_r [2];
  logic               s6_ok;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tdiff[k] = 39'(s5_pa[k]) - 39'(s5_pb[k]);
    end
    for (int k = 0; k < 2; k++) begin
      rdiff[k] = 37'(s5_ra[k]) - 37'(s5_rb[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s6_t[k] <= tdiff[k][38] ? 39'(-tdiff[k]) : 39'(tdiff[k]);
      end
      for (int k = 0; k < 2; k++) begin
        s6_r[k] <= rdiff[k][36] ? 37'(-rdiff[k]) : 37'(rdiff[k]);
      end
      s6_ok <= s5_ok;
    end
  end

  // Stage 7: area sums and result.
  logic [40:0] tri_sum;
  logic [37:0] rect_sum;
  logic        centre_in;
  assign tri_sum   = 41'(s6_t[0]) + 41'(s6_t[1]) + 41'(s6_t[2]) + 41'(s6_t[3]);
  assign rect_sum  = 38'(s6_r[0]) + 38'(s6_r[1]);
  assign centre_in = tri_sum == 41'(rect_sum);

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'b0, centre_in, centre_in && s6_ok};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
    else $error("matched without centre inside");

  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(vld)))
    else $error("pipeline moved during stall");

endmodule

[tb/sv/tb_rotated_box_cluster_match_top.sv]
module tb_rotated_box_cluster_match_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rbcm_pkg::*;

  typedef struct packed {
    logic [16:0] box_x;
    logic [16:0] box_y;
    logic [13:0] box_length;
    logic [13:0] box_width;
    logic [11:0] box_height;
    logic [15:0] box_yaw;
    logic [16:0] cluster_x;
    logic [16:0] cluster_y;
    logic [14:0] cluster_diagonal;
    logic [11:0] cluster_height;
  } pair_t;

  typedef struct {
    logic matched;
    logic centre_in;
  } flags_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [151:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic cfg_wen = 1'b0;
  logic cfg_addr = 1'b0;
  logic [13:0] cfg_wdata = '0;

  longint unsigned height_limit = 256;
  longint unsigned length_limit = 256;
  flags_t match_queue[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int ready_wait = 0;
  bit stall_free = 1'b0;

  localparam int unsigned SineTab[33] = '{
    0, 804, 1606, 2404, 3196, 3981, 4756, 5520, 6270, 7005, 7723,
    8423, 9102, 9760, 10394, 11003, 11585, 12140, 12665, 13160, 13623,
    14053, 14449, 14811, 15137, 15426, 15679, 15893, 16069, 16207, 16305,
    16364, 16384};

  rotated_box_cluster_match_top u_dut (.*);

  always #6 clk = ~clk;

  function automatic longint quarter_wave(int unsigned u);
    int unsigned i;
    int unsigned f;
    if (u >= 16384) return 16384;
    i = u >> 9;
    f = u & 511;
    return SineTab[i] + (((SineTab[i+1] - SineTab[i]) * f + 256) >> 9);
  endfunction

  function automatic longint sine_fixed(int unsigned a);
    int unsigned q;
    int unsigned r;
    longint m;
    a = a & 16'hFFFF;
    q = a >> 14;
    r = a & 16'h3FFF;
    m = q[0] ? quarter_wave(16384 - r) : quarter_wave(r);
    return q[1] ? -m : m;
  endfunction

  function automatic longint to_q8(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic longint tri_area(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
    longint s;
    s = ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
    return s < 0 ? -s : s;
  endfunction

  function automatic flags_t predict_match(pair_t p);
    flags_t r;
    longint len, wid, dg, hd, d, s, c, lc, ls, wc, ws, px, py, rect, sum;
    longint x0, y0, x1, y1, x2, y2, x3, y3;
    len = p.box_length;
    wid = p.box_width;
    dg = p.cluster_diagonal;
    s = sine_fixed(p.box_yaw);
    c = sine_fixed(p.box_yaw + 16384);
    lc = len * c; ls = len * s; wc = wid * c; ws = wid * s;
    x0 = to_q8(lc - ws);  y0 = to_q8(ls + wc);
    x1 = to_q8(lc + ws);  y1 = to_q8(ls - wc);
    x2 = to_q8(-lc + ws); y2 = to_q8(-ls - wc);
    x3 = to_q8(-lc - ws); y3 = to_q8(-ls + wc);
    px = longint'($signed(p.cluster_x)) - longint'($signed(p.box_x));
    py = longint'($signed(p.cluster_y)) - longint'($signed(p.box_y));
    rect = tri_area(x0, y0, x1, y1, x2, y2) + tri_area(x0, y0, x2, y2, x3, y3);
    sum = tri_area(px, py, x0, y0, x1, y1) + tri_area(px, py, x1, y1, x2, y2)
        + tri_area(px, py, x2, y2, x3, y3) + tri_area(px, py, x3, y3, x0, y0);
    r.centre_in = (sum == rect);
    hd = longint'(p.box_height) - longint'(p.cluster_height);
    if (hd < 0) hd = -hd;
    r.matched = r.centre_in;
    if (hd > longint'(height_limit)) r.matched = 1'b0;
    if (wid - dg > longint'(length_limit)) r.matched = 1'b0;
    d = dg - longint'(length_limit);
    if (d > 0 && d * d > len * len + wid * wid) r.matched = 1'b0;
    return r;
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (match_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_threshold(reg_index_t idx, logic [13:0] value);
    wait_drained();
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_HEIGHT_THRESHOLD) height_limit = value & 12'hFFF;
    else length_limit = value;
  endtask

  task automatic send_pair(pair_t p, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, p.cluster_height, p.cluster_diagonal, p.cluster_y, p.cluster_x,
                p.box_yaw, p.box_height, p.box_width, p.box_length,
                p.box_y, p.box_x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    match_queue.insert(match_queue.size(), predict_match(p));
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    p = pair_t'(152'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if ($urandom_range(0, 3) != 0) begin
      p.box_length = 14'($urandom_range(0, 2000));
      p.box_width = 14'($urandom_range(0, 2000));
      p.box_x = $signed(17'($urandom_range(0, 8000))) - 17'sd4000;
      p.box_y = $signed(17'($urandom_range(0, 8000))) - 17'sd4000;
      p.cluster_x = p.box_x + 17'($urandom_range(0, 1200)) - 17'd600;
      p.cluster_y = p.box_y + 17'($urandom_range(0, 1200)) - 17'd600;
      p.cluster_diagonal = 15'($urandom_range(0, 3000));
      p.cluster_height = p.box_height + 12'($urandom_range(0, 600)) - 12'd300;
    end
    return p;
  endfunction

  task automatic test_corners_and_edges();
    pair_t p;
    p = '0;
    send_pair(p);
    p.box_length = 512; p.box_width = 256;
    p.cluster_x = 256; p.cluster_y = 128;
    send_pair(p);
    p.cluster_x = 257;
    send_pair(p);
    p.box_yaw = 16384; p.cluster_x = 128; p.cluster_y = 256;
    send_pair(p);
    p.box_yaw = 8192; p.cluster_x = 0; p.cluster_y = 0;
    send_pair(p);
    p.box_yaw = 16'hFFFF; send_pair(p);
    p.box_yaw = 32768; send_pair(p);
    p.box_yaw = 49152; send_pair(p);
    p.box_width = 0; p.cluster_x = 100; p.cluster_y = 0; p.box_yaw = 0;
    send_pair(p);
    p.cluster_y = 1; send_pair(p);
    p.box_length = 0; p.cluster_x = 17'h10000; p.cluster_y = 17'h0FFFF;
    send_pair(p);
  endtask

  task automatic test_field_extremes();
    pair_t p;
    p = '1;
    send_pair(p);
    p.box_x = 17'h10000; p.box_y = 17'h0FFFF; p.cluster_x = 17'h0FFFF;
    p.cluster_y = 17'h10000;
    send_pair(p);
    p = '0;
    p.box_length = 14'h3FFF; p.box_width = 14'h3FFF; p.box_height = 12'hFFF;
    p.cluster_diagonal = 15'h7FFF;
    send_pair(p);
    p.cluster_diagonal = 0; p.cluster_height = 12'hFFF;
    send_pair(p);
    p.box_length = 300; p.box_width = 400; p.cluster_diagonal = 756;
    send_pair(p);
    p.cluster_diagonal = 757; send_pair(p);
    p.box_width = 656; p.cluster_diagonal = 400; send_pair(p);
    p.box_width = 657; send_pair(p);
    p.box_height = 500; p.cluster_height = 244; p.box_width = 100; send_pair(p);
    p.cluster_height = 243; send_pair(p);
  endtask

  task automatic test_random_pairs(int count);
    repeat (count) send_pair(random_pair());
  endtask

  task automatic test_back_to_back(int count);
    stall_free = 1'b1;
    repeat (count) send_pair(random_pair(), 1'b1);
    wait_drained();
    stall_free = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_corners_and_edges();
    test_field_extremes();
    test_random_pairs(80);
    write_threshold(REG_HEIGHT_THRESHOLD, 14'd0);
    write_threshold(REG_LENGTH_THRESHOLD, 14'd0);
    test_field_extremes();
    test_random_pairs(80);
    write_threshold(REG_HEIGHT_THRESHOLD, 14'h0FFF);
    write_threshold(REG_LENGTH_THRESHOLD, 14'h3FFF);
    test_random_pairs(80);
    test_back_to_back(40);
    write_threshold(REG_HEIGHT_THRESHOLD, 14'($urandom_range(0, 400)));
    write_threshold(REG_LENGTH_THRESHOLD, 14'($urandom_range(0, 800)));
    test_random_pairs(100);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk) begin
    int wait_draw;
    if (rst) begin
      m_tready <= 1'b0;
      ready_wait <= 0;
    end else if (stall_free) begin
      m_tready <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      wait_draw = $urandom_range(0, 18);
      m_tready <= (wait_draw == 0);
      ready_wait <= wait_draw;
    end else if (ready_wait > 0) begin
      m_tready <= (ready_wait == 1);
      ready_wait <= ready_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    flags_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (match_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result word %h", m_tdata);
      end else begin
        e = match_queue.pop_front();
        if (m_tdata[0] !== e.matched || m_tdata[1] !== e.centre_in || m_tdata[7:2] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result word: expected matched=%0b inside=%0b, got %b",
                     e.matched, e.centre_in, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

[sim.f]
src/rbcm_pkg.sv
src/rbcm_sincos.sv
src/rotated_box_cluster_match_top.sv
tb/sv/tb_rotated_box_cluster_match_top.sv
